@@ src/oaie_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ordered array block: sizes, codes, controller/datapath structs,
// and word conversion helpers. No dependencies.
package oaie_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int POS2_W    = 6;
    localparam int VAL_W     = 32;
    localparam int STS_W     = 2;
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT,
        CMD_ERASE,
        CMD_READ,
        CMD_SWAP,
        CMD_CLEAR,
        CMD_RESIZE,
        CMD_PUSH,
        CMD_POP
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        ST_OK,
        ST_RANGE,
        ST_FULL
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SH_WR,
        S_INS_WR,
        S_ER_DONE,
        S_RD_CAP,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_FILL,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_EXEC,
        DP_SH_RD,
        DP_SH_WR,
        DP_INS_WR,
        DP_ER_DONE,
        DP_RD_CAP,
        DP_SW_RB,
        DP_SW_WA,
        DP_SW_WB,
        DP_FILL_WR,
        DP_FILL_END
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
        logic   out_load;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic reject;
        logic shift_done;
        logic fill_done;
        logic out_free;
    } t_dp_sts;

    function automatic t_word to_word(input logic [VAL_W-1:0] v);
        return t_word'(signed'(v));
    endfunction

    function automatic logic [VAL_W-1:0] from_word(input t_word w);
        return VAL_W'(signed'(w));
    endfunction

endpackage

@@ src/ordered_array_insert_erase.sv @@
`timescale 1ns / 1ps
// Insert and erase shift stored entries one at a time, each by a store read and then a write;
// resize zero-fills the entries from the old count up to the new size, then sets the count.
// The element store has a single read port and a single write port. Next input transfer is
// taken in idle after the result is registered, while that result may still wait.
// Reset clears the live count and result valid; store contents stay undefined, no clear pass.
module ordered_array_insert_erase
    import oaie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [POS_W-1:0]         i_position,
    input  logic [POS2_W-1:0]        i_second_position,
    input  logic signed [VAL_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [VAL_W-1:0]  o_read_value,
    output logic [POS_W-1:0]         o_element_count,
    output logic [STS_W-1:0]         o_status
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    oaie_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    oaie_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_read_value      (o_read_value),
        .o_element_count   (o_element_count),
        .o_status          (o_status)
    );

endmodule

@@ src/oaie_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oaie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/oaie_dp.sv @@
`timescale 1ns / 1ps
// Datapath: command registers, live count, walk index, element store RAM, result register.
// Depends on oaie_pkg and oaie_ram.
module oaie_dp
    import oaie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_ctl                  i_ctl,
    output t_dp_sts                  o_sts,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [POS_W-1:0]         i_position,
    input  logic [POS2_W-1:0]        i_second_position,
    input  logic signed [VAL_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [VAL_W-1:0]  o_read_value,
    output logic [POS_W-1:0]         o_element_count,
    output logic [STS_W-1:0]         o_status
);

    t_cmd               r_cmd;
    logic [POS_W-1:0]   r_pos;
    logic [POS2_W-1:0]  r_pos2;
    t_word              r_word;
    t_word              r_tmp;
    logic [VAL_W-1:0]   r_rd;
    t_status            r_status;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_value;
    logic [POS_W-1:0]   r_out_count;
    t_status            r_out_status;

    logic [CMP_W-1:0]   w_pos, w_pos2, w_cnt, w_cap, w_idx;
    t_status            w_status;
    logic [CNT_W-1:0]   idx_m1, idx_p1;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_word              ram_wdata, ram_rdata;

    assign w_pos  = CMP_W'(r_pos);
    assign w_pos2 = CMP_W'(r_pos2);
    assign w_cnt  = CMP_W'(r_count);
    assign w_cap  = CMP_W'(CAPACITY);
    assign w_idx  = CMP_W'(r_idx);
    assign idx_m1 = r_idx - 1'b1;
    assign idx_p1 = r_idx + 1'b1;

    always_comb begin
        w_status = ST_OK;
        unique case (r_cmd) inside
            CMD_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (w_cnt == w_cap) begin
                    w_status = ST_FULL;
                end
            end
            CMD_ERASE, CMD_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end
            end
            CMD_SWAP: begin
                if (w_pos >= w_cnt || w_pos2 >= w_cnt) begin
                    w_status = ST_RANGE;
                end
            end
            CMD_CLEAR: begin
                w_status = ST_OK;
            end
            CMD_RESIZE: begin
                if (w_pos > w_cap) begin
                    w_status = ST_RANGE;
                end
            end
            CMD_PUSH: begin
                if (w_cnt >= w_cap) begin
                    w_status = ST_FULL;
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    w_status = ST_RANGE;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.reject     = (w_status != ST_OK);
        o_sts.shift_done = (r_cmd == CMD_INSERT) ? (w_idx == w_pos)
                                                 : ((w_idx + 1'b1) >= w_cnt);
        o_sts.fill_done  = (w_idx >= w_pos);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // element store port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = IDX_W'(r_pos);
        unique case (i_ctl.op)
            DP_EXEC: begin
                if (r_cmd == CMD_PUSH && w_status == ST_OK) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = r_word;
                end
            end
            DP_SH_RD: begin
                ram_raddr = (r_cmd == CMD_INSERT) ? idx_m1[IDX_W-1:0] : idx_p1[IDX_W-1:0];
            end
            DP_SH_WR: begin
                ram_we = 1'b1;
            end
            DP_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_pos);
                ram_wdata = r_word;
            end
            DP_SW_RB: begin
                ram_raddr = IDX_W'(r_pos2);
            end
            DP_SW_WA: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_pos);
            end
            DP_SW_WB: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_pos2);
                ram_wdata = r_tmp;
            end
            DP_FILL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        unique case (i_ctl.op)
            DP_EXEC: begin
                if (w_status == ST_OK) begin
                    unique case (r_cmd)
                        CMD_CLEAR: n_count = '0;
                        CMD_PUSH:  n_count = r_count + 1'b1;
                        CMD_POP:   n_count = r_count - 1'b1;
                        default:   n_count = r_count;
                    endcase
                end
            end
            DP_INS_WR:   n_count = r_count + 1'b1;
            DP_ER_DONE:  n_count = r_count - 1'b1;
            DP_FILL_END: n_count = CNT_W'(r_pos);
            default:     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_pos  <= i_position;
            r_pos2 <= i_second_position;
            r_word <= to_word(i_value);
        end
        unique case (i_ctl.op)
            DP_EXEC: begin
                r_status <= w_status;
                r_rd     <= '0;
                if (r_cmd == CMD_ERASE) begin
                    r_idx <= CNT_W'(r_pos);
                end else begin
                    r_idx <= r_count;
                end
            end
            DP_SH_WR:   r_idx <= (r_cmd == CMD_INSERT) ? idx_m1 : idx_p1;
            DP_RD_CAP:  r_rd  <= from_word(ram_rdata);
            DP_SW_RB:   r_tmp <= ram_rdata;
            DP_FILL_WR: r_idx <= idx_p1;
            default: ;
        endcase
        if (i_ctl.out_load) begin
            r_out_value  <= r_rd;
            r_out_count  <= POS_W'(r_count);
            r_out_status <= r_status;
        end
    end

    oaie_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = signed'(r_out_value);
    assign o_element_count = r_out_count;
    assign o_status        = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= w_cap)
        else $error("live count above capacity");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == DP_EXEC && w_status != ST_OK) |=> $stable(r_count))
        else $error("rejected command changed the count");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == DP_NONE) |-> !ram_we)
        else $error("store written without a command");

endmodule

@@ src/oaie_ctl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences each command over the datapath.
// Depends on oaie_pkg.
module oaie_ctl
    import oaie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl.load     = 1'b0;
        o_ctl.op       = DP_NONE;
        o_ctl.out_load = 1'b0;
        o_in_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.op = DP_EXEC;
                if (i_sts.reject) begin
                    n_state = S_FINISH;
                end else begin
                    unique case (i_sts.cmd) inside
                        CMD_INSERT, CMD_ERASE: n_state = S_SHIFT;
                        CMD_READ:              n_state = S_RD_CAP;
                        CMD_SWAP:              n_state = S_SW_RB;
                        CMD_RESIZE:            n_state = S_FILL;
                        default:               n_state = S_FINISH;
                    endcase
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = (i_sts.cmd == CMD_INSERT) ? S_INS_WR : S_ER_DONE;
                end else begin
                    o_ctl.op = DP_SH_RD;
                    n_state  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_ctl.op = DP_SH_WR;
                n_state  = S_SHIFT;
            end
            S_INS_WR: begin
                o_ctl.op = DP_INS_WR;
                n_state  = S_FINISH;
            end
            S_ER_DONE: begin
                o_ctl.op = DP_ER_DONE;
                n_state  = S_FINISH;
            end
            S_RD_CAP: begin
                o_ctl.op = DP_RD_CAP;
                n_state  = S_FINISH;
            end
            S_SW_RB: begin
                o_ctl.op = DP_SW_RB;
                n_state  = S_SW_WA;
            end
            S_SW_WA: begin
                o_ctl.op = DP_SW_WA;
                n_state  = S_SW_WB;
            end
            S_SW_WB: begin
                o_ctl.op = DP_SW_WB;
                n_state  = S_FINISH;
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    o_ctl.op = DP_FILL_END;
                    n_state  = S_FINISH;
                end else begin
                    o_ctl.op = DP_FILL_WR;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("transfer not followed by execute");

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

endmodule
